[rtl/core/array_priority_queue_assert.svh]
// Assertion macros for the priority queue RTL.
// Included by the top level; no other dependencies.
`ifndef ARRAY_PRIORITY_QUEUE_ASSERT_SVH
`define ARRAY_PRIORITY_QUEUE_ASSERT_SVH

// Condition a implies condition b in the same cycle.
`define APQ_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("array_priority_queue: implication check failed");

// Condition a implies condition b in the next cycle.
`define APQ_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("array_priority_queue: next-cycle check failed");

`endif

[rtl/core/apq_pkg.sv]
// Shared types and codes for the array priority queue.
// No dependencies.
package apq_pkg;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_FRONT = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // One stored queue entry.
  typedef struct packed {
    logic signed [31:0] value;
    logic [7:0]         prio;
  } entry_t;

  // Result word minus occupancy (occupancy width follows DEPTH).
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] value;
    logic [7:0]         prio;
  } result_t;

endpackage

[rtl/core/apq_mem.sv]
// Entry store: one write port, one read port, registered read data.
// Depends on apq_pkg.
module apq_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  apq_pkg::entry_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output apq_pkg::entry_t rd_data
);
  import apq_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/apq_seq.sv]
// Operation sequencer: push, front scan, pop scan and shift-down.
// Depends on apq_pkg; drives the ports of apq_mem.
module apq_seq #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int CW    = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       op,
  input  apq_pkg::entry_t  in_entry,
  input  logic             res_ready,
  output logic             res_valid,
  output apq_pkg::result_t res,
  output logic [CW-1:0]    res_occ,
  output logic             wr_en,
  output logic [AW-1:0]    wr_addr,
  output apq_pkg::entry_t  wr_data,
  output logic             rd_en,
  output logic [AW-1:0]    rd_addr,
  input  apq_pkg::entry_t  rd_data
);
  import apq_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]    state;
  logic [CW-1:0] count;
  logic [7:0]    highest;
  logic [AW-1:0] ptr;       // scan: index of the entry on rd_data; shift: write index
  logic [7:0]    max_acc;   // max priority of the entries kept so far
  logic          is_pop;
  result_t       hold;

  logic          accept;
  logic          is_full;
  logic          is_empty;
  logic          is_fetch_op;
  logic [CW-1:0] ptr_ext;
  logic          scan_last;
  logic          scan_match;
  logic          shift_last;
  logic [7:0]    max_with_rd;

  assign is_full     = (count == CW'(DEPTH));
  assign is_empty    = (count == '0);
  assign is_fetch_op = op inside {OP_POP, OP_FRONT};
  assign in_stall    = rst || !((state == S_IDLE) && res_ready);
  assign accept      = in_valid && !in_stall;
  assign ptr_ext     = CW'(ptr);
  assign scan_last   = (ptr_ext + CW'(1)) == count;
  assign scan_match  = (rd_data.prio == highest) || scan_last;
  assign shift_last  = (ptr_ext + CW'(2)) == count;
  assign max_with_rd = (rd_data.prio > max_acc) ? rd_data.prio : max_acc;

  // Memory port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr;
    wr_data = rd_data;
    rd_en   = 1'b0;
    rd_addr = ptr + AW'(1);
    case (state)
      S_IDLE: begin
        wr_en   = accept && (op == OP_PUSH) && !is_full;
        wr_addr = count[AW-1:0];
        wr_data = in_entry;
        rd_en   = accept && is_fetch_op && !is_empty;
        rd_addr = '0;
      end
      S_SCAN: begin
        rd_en = !scan_last && (!scan_match || is_pop);
      end
      S_SHIFT: begin
        wr_en   = 1'b1;
        rd_en   = !shift_last;
        rd_addr = ptr + AW'(2);
      end
      default: begin
      end
    endcase
  end

  // Result toward the output register
  always_comb begin
    res_valid   = 1'b0;
    res.status  = ST_OK;
    res.value   = '0;
    res.prio    = '0;
    res_occ     = count;
    if (state == S_IDLE) begin
      res_valid = accept && (!is_fetch_op || is_empty);
      if (op == OP_PUSH) begin
        if (is_full) begin
          res.status = ST_FULL;
        end else begin
          res_occ = count + CW'(1);
        end
      end else if (is_fetch_op) begin
        res.status = ST_EMPTY;
      end
    end else if (state == S_DONE) begin
      res_valid = 1'b1;
      res       = hold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      highest <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            ptr     <= '0;
            max_acc <= '0;
            is_pop  <= (op == OP_POP);
            if (op == OP_PUSH && !is_full) begin
              count <= count + CW'(1);
              if (in_entry.prio > highest) begin
                highest <= in_entry.prio;
              end
            end
            if (is_fetch_op && !is_empty) begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (!scan_match) begin
            max_acc <= max_with_rd;
            ptr     <= ptr + AW'(1);
          end else begin
            hold.status <= ST_OK;
            hold.value  <= rd_data.value;
            hold.prio   <= rd_data.prio;
            if (!is_pop) begin
              state <= S_DONE;
            end else if (scan_last) begin
              count   <= count - CW'(1);
              highest <= max_acc;
              state   <= S_DONE;
            end else begin
              state <= S_SHIFT;
            end
          end
        end
        S_SHIFT: begin
          if (shift_last) begin
            count   <= count - CW'(1);
            highest <= max_with_rd;
            state   <= S_DONE;
          end else begin
            max_acc <= max_with_rd;
            ptr     <= ptr + AW'(1);
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/array_priority_queue.sv]
// Array priority queue, top level: sequencer, entry memory and output register.
// Depends on apq_pkg, apq_mem, apq_seq and array_priority_queue_assert.svh.
//
// Unsorted-array priority queue of up to DEPTH (value, priority) entries kept
// in one synchronous memory in arrival order. Each input word is a push, a pop
// or a front query and yields exactly one result word. A push, a refused push,
// an operation on an empty queue and the unused code are answered straight from
// the idle state, with no memory scan. A front query reads the memory from
// entry 0 until it meets the first entry at the highest priority. A pop does
// that scan and then moves every later entry down one place while rescanning
// for the new maximum, one entry per cycle through the single read and write
// port. One operation is in flight at a time, and a new word is taken only
// while the output register is empty or being drained in that cycle, so a
// result held by a stalled receiver also holds off the input. Entries are only
// ever read below the fill count, so the memory needs no clearing after reset.
module array_priority_queue #(
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          operation,
  input  logic signed [31:0]  item_value,
  input  logic [7:0]          item_priority,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic signed [31:0]  out_value,
  output logic [7:0]          out_priority,
  output logic [CW-1:0]       occupancy
);
  import apq_pkg::*;

  `include "array_priority_queue_assert.svh"

  entry_t        in_entry;
  logic          res_ready;
  logic          res_valid;
  result_t       res;
  logic [CW-1:0] res_occ;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;

  assign in_entry.value = item_value;
  assign in_entry.prio  = item_priority;

  apq_seq #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (operation),
    .in_entry  (in_entry),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_occ   (res_occ),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  apq_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Output register: loads whenever it is empty or being drained.
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      status       <= res.status;
      out_value    <= res.value;
      out_priority <= res.prio;
      occupancy    <= res_occ;
    end
  end

  // A refused push only happens at capacity; an empty status only when empty.
  `APQ_ASSERT_IMPLY(a_full_at_depth, clk, rst, out_valid && (status == ST_FULL), occupancy == CW'(DEPTH))
  `APQ_ASSERT_IMPLY(a_empty_at_zero, clk, rst, out_valid && (status == ST_EMPTY), occupancy == '0)
  // The sequencer only hands over a result when the output register can take it.
  `APQ_ASSERT_NEXT(a_result_lands, clk, rst, res_valid && res_ready, out_valid)

endmodule
